### sv/eqm_pkg.sv
package eqm_pkg;

    // Angle unit: pi = 2^31, carried in 34-bit signed words.
    localparam int ANG_W = 34;
    localparam int TAB_LEN = 24;
    localparam int GAIN_Q16 = 107922;
    localparam int ADDR_W = 16;
    localparam int RGB_W = 24;

    // Input function codes.
    localparam logic FUNC_WRITE = 1'b0;
    localparam logic FUNC_LOOKUP = 1'b1;

    // Configuration register indexes.
    localparam logic REG_WIDTH = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;

    typedef logic signed [ANG_W-1:0] t_ang;

    // Table of atan(2^-i) in the angle unit.
    function automatic t_ang atan_lut(input int i);
        t_ang r;
        unique case (i)
            0: r = 34'sd536870912;
            1: r = 34'sd316933406;
            2: r = 34'sd167458907;
            3: r = 34'sd85004756;
            4: r = 34'sd42667331;
            5: r = 34'sd21354465;
            6: r = 34'sd10679838;
            7: r = 34'sd5340245;
            8: r = 34'sd2670163;
            9: r = 34'sd1335087;
            10: r = 34'sd667544;
            11: r = 34'sd333772;
            12: r = 34'sd166886;
            13: r = 34'sd83443;
            14: r = 34'sd41722;
            15: r = 34'sd20861;
            16: r = 34'sd10430;
            17: r = 34'sd5215;
            18: r = 34'sd2608;
            19: r = 34'sd1304;
            20: r = 34'sd652;
            21: r = 34'sd326;
            22: r = 34'sd163;
            23: r = 34'sd81;
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

### sv/equirect_env_map_lookup_top.sv
// Channel   | Direction | Handshake          | Payload
// request   | in        | i_start & !o_busy  | i_func, i_texel_index, i_texel_rgb, i_dir_*
// config    | in        | i_cfg_valid&ready  | i_cfg_index, i_cfg_data
// result    | out       | o_strobe (1 cycle) | o_red, o_green, o_blue, o_col, o_row
//
// One request is taken every cycle; o_busy is held low after reset.
// A lookup result passes the longitude CORDIC chain, the gain register, the latitude
// CORDIC chain, the scale and address registers and the registered texel memory read.
// Writes travel a matching delay line, so the texel memory sees reads and writes
// in request order; writes give no result.
// Reset is synchronous and clears only the valid pipeline and registers.
// The receiver cannot stall; results are never held back.
module equirect_env_map_lookup_top import eqm_pkg::*; #(
    parameter int MAX_WIDTH = 256,
    parameter int MAX_HEIGHT = 256,
    parameter int CORDIC_STEPS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    output logic               o_busy,
    input  logic               i_func,
    input  logic [15:0]        i_texel_index,
    input  logic [23:0]        i_texel_rgb,
    input  logic signed [15:0] i_dir_x,
    input  logic signed [15:0] i_dir_y,
    input  logic signed [15:0] i_dir_z,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic               i_cfg_index,
    input  logic [8:0]         i_cfg_data,
    output logic               o_strobe,
    output logic [7:0]         o_red,
    output logic [7:0]         o_green,
    output logic [7:0]         o_blue,
    output logic [7:0]         o_col,
    output logic [7:0]         o_row
);

    localparam int VW = 38;
    localparam int TW = VW + 1;
    localparam logic signed [ANG_W-1:0] APi = 34'sd2147483648;
    localparam int NS = (CORDIC_STEPS > TAB_LEN) ? TAB_LEN : CORDIC_STEPS;
    localparam int WD = 2 * NS + 4;

    logic [8:0] r_width, r_height;
    logic       r_busy;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= 9'd256;
            r_height <= 9'd128;
            r_busy   <= 1'b0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_WIDTH:  r_width  <= i_cfg_data;
                REG_HEIGHT: r_height <= i_cfg_data;
                default:    r_width  <= r_width;
            endcase
        end
    end
    assign o_busy      = r_busy;
    assign o_cfg_ready = 1'b1;

    logic acc, lk, wr;
    assign acc = i_start && !r_busy;
    assign lk  = acc && (i_func == FUNC_LOOKUP);
    assign wr  = acc && (i_func == FUNC_WRITE);

    // Longitude CORDIC; scaled y travels as the tag, plus a zero flag for later.
    logic signed [VW-1:0] x0, z0, y0;
    assign x0 = VW'(i_dir_x) <<< 14;
    assign z0 = VW'(i_dir_z) <<< 14;
    assign y0 = VW'(i_dir_y) <<< 14;

    logic                 c1_v;
    logic signed [VW-1:0] c1_mag;
    t_ang                 c1_ang;
    logic [TW-1:0]        c1_tag;

    eqm_cordic #(.STEPS(CORDIC_STEPS), .VW(VW), .TW(TW)) u_lon (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(lk),
        .i_zero(i_dir_x == 16'sd0 && i_dir_z == 16'sd0),
        .i_x(x0), .i_y(z0), .i_tag({1'b0, y0}),
        .o_valid(c1_v), .o_mag(c1_mag), .o_ang(c1_ang), .o_tag(c1_tag));

    // Gain compensation of y, registered.
    logic                 r_k_v;
    logic signed [VW-1:0] r_k_mag, r_ky;
    t_ang                 r_k_lon;
    logic signed [VW+17:0] kprod;
    assign kprod = $signed(c1_tag[VW-1:0]) * $signed({1'b0, 17'(GAIN_Q16)});
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k_v <= 1'b0;
        end else begin
            r_k_v <= c1_v;
        end
        r_k_mag <= c1_mag;
        r_k_lon <= c1_ang;
        r_ky    <= VW'(kprod >>> 16);
    end

    logic                 c2_v;
    logic signed [VW-1:0] c2_mag;
    t_ang                 c2_ang;
    logic [TW-1:0]        c2_tag;

    eqm_cordic #(.STEPS(CORDIC_STEPS), .VW(VW), .TW(TW)) u_lat (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(r_k_v),
        .i_zero(r_k_mag == '0 && r_ky == '0),
        .i_x(r_k_mag), .i_y(r_ky), .i_tag(TW'(r_k_lon)),
        .o_valid(c2_v), .o_mag(c2_mag), .o_ang(c2_ang), .o_tag(c2_tag));

    // u and v in unsigned Q1.16 with clamp.
    logic signed [ANG_W:0] ue, ve;
    logic [16:0] u_c, v_c;
    assign ue = (ANG_W+1)'($signed(c2_tag[ANG_W-1:0])) + (ANG_W+1)'(APi);
    assign ve = (ANG_W+1)'(APi >>> 1) - (ANG_W+1)'(c2_ang);
    always_comb begin
        if (ue < 0) u_c = '0;
        else if ((ue >>> 15) > 65536) u_c = 17'd65536;
        else u_c = 17'(ue >>> 15);
        if (ve < 0) v_c = '0;
        else if ((ve >>> 14) > 65536) v_c = 17'd65536;
        else v_c = 17'(ve >>> 14);
    end

    // Effective sizes.
    logic [12:0] w_e, h_e;
    always_comb begin
        if (r_width == 0) w_e = 13'd1;
        else if (32'(r_width) > MAX_WIDTH) w_e = 13'(MAX_WIDTH);
        else w_e = 13'(r_width);
        if (r_height == 0) h_e = 13'd1;
        else if (32'(r_height) > MAX_HEIGHT) h_e = 13'(MAX_HEIGHT);
        else h_e = 13'(r_height);
    end

    logic        r_m_v;
    logic [29:0] r_cp, r_rp;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_v <= 1'b0;
        end else begin
            r_m_v <= c2_v;
        end
        r_cp <= 30'(u_c) * 30'(w_e);
        r_rp <= 30'(v_c) * 30'(h_e);
    end

    logic [13:0] colw, roww;
    always_comb begin
        colw = r_cp[29:16];
        roww = r_rp[29:16];
        if (colw >= 14'(w_e)) colw = '0;
        if (roww >= 14'(h_e)) roww = '0;
    end

    logic        r_a_v;
    logic [7:0]  r_a_col, r_a_row;
    logic [25:0] r_rw;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
        end else begin
            r_a_v <= r_m_v;
        end
        r_a_col <= colw[7:0];
        r_a_row <= roww[7:0];
        r_rw    <= 26'(roww) * 26'(w_e) + 26'(colw);
    end

    // Write requests follow the lookup pipeline so that each one reaches the
    // memory in request order relative to the lookup reads.
    logic              r_wv   [0:WD-1];
    logic [ADDR_W-1:0] r_widx [0:WD-1];
    logic [RGB_W-1:0]  r_wdat [0:WD-1];
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < WD; k++) r_wv[k] <= 1'b0;
        end else begin
            r_wv[0] <= wr;
            for (int k = 1; k < WD; k++) r_wv[k] <= r_wv[k-1];
        end
        r_widx[0] <= i_texel_index;
        r_wdat[0] <= i_texel_rgb;
        for (int k = 1; k < WD; k++) begin
            r_widx[k] <= r_widx[k-1];
            r_wdat[k] <= r_wdat[k-1];
        end
    end

    // Texel memory: one write port, one registered read port.
    logic [RGB_W-1:0] mem [0:(1<<ADDR_W)-1];
    logic [RGB_W-1:0] r_q;
    always_ff @(posedge i_clk) begin
        if (r_wv[WD-1]) begin
            mem[r_widx[WD-1]] <= r_wdat[WD-1];
        end
        r_q <= mem[r_rw[ADDR_W-1:0]];
    end

    logic       r_o_v;
    logic [7:0] r_o_col, r_o_row;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_v <= 1'b0;
        end else begin
            r_o_v <= r_a_v;
        end
        r_o_col <= r_a_col;
        r_o_row <= r_a_row;
    end

    assign o_strobe = r_o_v;
    assign o_red    = r_q[23:16];
    assign o_green  = r_q[15:8];
    assign o_blue   = r_q[7:0];
    assign o_col    = r_o_col;
    assign o_row    = r_o_row;

    // A result follows its address stage in the next cycle.
    a_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_a_v |=> o_strobe) else $error("result strobe lost");
    // The column never reaches the effective width.
    a_col: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_m_v |-> (colw < 14'(w_e))) else $error("column out of range");
    // The row never reaches the effective height.
    a_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_m_v |-> (roww < 14'(h_e))) else $error("row out of range");

endmodule

### sv/eqm_cordic.sv
// Pipelined vectoring CORDIC: one stage per iteration, one vector per cycle.
module eqm_cordic import eqm_pkg::*; #(
    parameter int STEPS = 16,
    parameter int VW = 38,
    parameter int TW = 40
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  logic                 i_zero,
    input  logic signed [VW-1:0] i_x,
    input  logic signed [VW-1:0] i_y,
    input  logic [TW-1:0]        i_tag,
    output logic                 o_valid,
    output logic signed [VW-1:0] o_mag,
    output t_ang                 o_ang,
    output logic [TW-1:0]        o_tag
);

    localparam int NS = (STEPS > TAB_LEN) ? TAB_LEN : STEPS;
    localparam logic signed [ANG_W-1:0] APi = 34'sd2147483648;

    logic                 r_v   [0:NS];
    logic signed [VW-1:0] r_x   [0:NS];
    logic signed [VW-1:0] r_y   [0:NS];
    t_ang                 r_a   [0:NS];
    logic [TW-1:0]        r_t   [0:NS];

    // Quadrant pre-rotation for a negative x; a zero vector gives angle 0.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else begin
            r_v[0] <= i_valid;
        end
        r_t[0] <= i_tag;
        if (i_x < 0) begin
            r_x[0] <= -i_x;
            r_y[0] <= -i_y;
            r_a[0] <= (i_y >= 0) ? APi : -APi;
        end else begin
            r_x[0] <= i_x;
            r_y[0] <= i_y;
            r_a[0] <= '0;
        end
    end

    // Zero flag rides along so the final angle can be forced to 0.
    logic r_z [0:NS];
    always_ff @(posedge i_clk) begin
        r_z[0] <= i_zero;
    end

    for (genvar g = 0; g < NS; g++) begin : g_stage
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[g+1] <= 1'b0;
            end else begin
                r_v[g+1] <= r_v[g];
            end
            r_t[g+1] <= r_t[g];
            r_z[g+1] <= r_z[g];
            if (r_y[g] < 0) begin
                r_x[g+1] <= r_x[g] - (r_y[g] >>> g);
                r_y[g+1] <= r_y[g] + (r_x[g] >>> g);
                r_a[g+1] <= r_a[g] - atan_lut(g);
            end else begin
                r_x[g+1] <= r_x[g] + (r_y[g] >>> g);
                r_y[g+1] <= r_y[g] - (r_x[g] >>> g);
                r_a[g+1] <= r_a[g] + atan_lut(g);
            end
        end
    end

    assign o_valid = r_v[NS];
    assign o_mag   = r_z[NS] ? '0 : r_x[NS];
    assign o_ang   = r_z[NS] ? '0 : r_a[NS];
    assign o_tag   = r_t[NS];

endmodule

### tb/tb_equirect_env_map_lookup_top.sv
module tb_equirect_env_map_lookup_top;
    import eqm_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_W = 256;
    localparam int MAX_H = 256;
    localparam int STEPS = 16;
    localparam int LATENCY = 2 * STEPS + 9;
    localparam int DRAIN_CYCLES = LATENCY + 8;
    localparam int CYCLE_LIMIT = 600000;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] col;
        logic [7:0] row;
    } t_texel_hit;

    // Own copy of atan(2^-i), pi = 2^31.
    localparam longint ATAN_STEP [24] = '{
        536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
        10679838, 5340245, 2670163, 1335087, 667544, 333772,
        166886, 83443, 41722, 20861, 10430, 5215,
        2608, 1304, 652, 326, 163, 81
    };

    logic               i_clk;
    logic               i_rst_n;
    logic               i_start;
    logic               o_busy;
    logic               i_func;
    logic [15:0]        i_texel_index;
    logic [23:0]        i_texel_rgb;
    logic signed [15:0] i_dir_x;
    logic signed [15:0] i_dir_y;
    logic signed [15:0] i_dir_z;
    logic               i_cfg_valid;
    logic               o_cfg_ready;
    logic               i_cfg_index;
    logic [8:0]         i_cfg_data;
    logic               o_strobe;
    logic [7:0]         o_red;
    logic [7:0]         o_green;
    logic [7:0]         o_blue;
    logic [7:0]         o_col;
    logic [7:0]         o_row;

    equirect_env_map_lookup_top #(
        .MAX_WIDTH(MAX_W),
        .MAX_HEIGHT(MAX_H),
        .CORDIC_STEPS(STEPS)
    ) u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(i_start), .o_busy(o_busy),
        .i_func(i_func), .i_texel_index(i_texel_index), .i_texel_rgb(i_texel_rgb),
        .i_dir_x(i_dir_x), .i_dir_y(i_dir_y), .i_dir_z(i_dir_z),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .o_strobe(o_strobe), .o_red(o_red), .o_green(o_green), .o_blue(o_blue),
        .o_col(o_col), .o_row(o_row)
    );

    // Shadow state of the block.
    logic [23:0]  sky_texels [int];
    logic [8:0]   width_reg;
    logic [8:0]   height_reg;
    t_texel_hit   pending_hits [$];
    int           error_count;
    longint       cycle_count;

    // Clock.
    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // Guard against a hung run.
    initial cycle_count = 0;
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // Vectoring rotation: returns the angle of (xx, yy), mag gets K times the length.
    function automatic longint vector_angle(input longint yy, input longint xx,
                                            output longint mag);
        longint x;
        longint y;
        longint ang;
        longint dx;
        longint dy;
        x = xx;
        y = yy;
        ang = 0;
        if (x < 0) begin
            ang = (yy >= 0) ? 64'sd2147483648 : -64'sd2147483648;
            x = -x;
            y = -y;
        end
        for (int i = 0; i < STEPS; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (y < 0) begin
                x = x - dx;
                y = y + dy;
                ang = ang - ATAN_STEP[i];
            end else begin
                x = x + dx;
                y = y - dy;
                ang = ang + ATAN_STEP[i];
            end
        end
        mag = x;
        return ang;
    endfunction

    // Map a direction to a texel column, row and linear address.
    task automatic map_direction(input logic signed [15:0] dx, input logic signed [15:0] dy,
                                 input logic signed [15:0] dz, output longint col,
                                 output longint row, output int addr);
        longint x;
        longint y;
        longint z;
        longint lon;
        longint lat;
        longint mag;
        longint ky;
        longint spare;
        longint ue;
        longint ve;
        longint w;
        longint h;
        x = longint'(dx) * 16384;
        y = longint'(dy) * 16384;
        z = longint'(dz) * 16384;
        lon = 0;
        lat = 0;
        mag = 0;
        if (x != 0 || z != 0)
            lon = vector_angle(z, x, mag);
        ky = (y * GAIN_Q16) >>> 16;
        if (mag != 0 || ky != 0)
            lat = vector_angle(ky, mag, spare);
        ue = lon + 64'sd2147483648;
        if (ue < 0)
            ue = 0;
        ue = ue >> 15;
        if (ue > 65536)
            ue = 65536;
        ve = 64'sd1073741824 - lat;
        if (ve < 0)
            ve = 0;
        ve = ve >> 14;
        if (ve > 65536)
            ve = 65536;
        w = (width_reg == 0) ? 1 : (width_reg > MAX_W) ? MAX_W : width_reg;
        h = (height_reg == 0) ? 1 : (height_reg > MAX_H) ? MAX_H : height_reg;
        col = (ue * w) >> 16;
        if (col >= w)
            col = 0;
        row = (ve * h) >> 16;
        if (row >= h)
            row = 0;
        addr = int'((row * w + col) & 64'hFFFF);
    endtask

    // Send one request, after a random gap, and wait until it is taken.
    task automatic send_request(input logic func, input logic [15:0] index,
                                input logic [23:0] rgb, input logic signed [15:0] dx,
                                input logic signed [15:0] dy, input logic signed [15:0] dz);
        int gap;
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 15);
        if (gap > 0) begin
            i_start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_start <= 1'b1;
        i_func <= func;
        i_texel_index <= index;
        i_texel_rgb <= rgb;
        i_dir_x <= dx;
        i_dir_y <= dy;
        i_dir_z <= dz;
        do @(posedge i_clk); while (o_busy);
    endtask

    task automatic write_texel(input logic [15:0] index, input logic [23:0] rgb);
        send_request(FUNC_WRITE, index, rgb, $urandom, $urandom, $urandom);
        sky_texels[int'(index)] = rgb;
    endtask

    // A lookup whose texel is still unwritten gets a write first.
    task automatic lookup_sky(input logic signed [15:0] dx, input logic signed [15:0] dy,
                              input logic signed [15:0] dz);
        longint col;
        longint row;
        int addr;
        t_texel_hit hit;
        map_direction(dx, dy, dz, col, row, addr);
        if (!sky_texels.exists(addr))
            write_texel(addr[15:0], $urandom);
        send_request(FUNC_LOOKUP, $urandom, $urandom, dx, dy, dz);
        hit.red = sky_texels[addr][23:16];
        hit.green = sky_texels[addr][15:8];
        hit.blue = sky_texels[addr][7:0];
        hit.col = col[7:0];
        hit.row = row[7:0];
        pending_hits.push_back(hit);
    endtask

    // Let every lookup in flight finish, then the tail of any write.
    task automatic drain_pipeline();
        i_start <= 1'b0;
        while (pending_hits.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_size(input logic idx, input logic [8:0] data);
        drain_pipeline();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        if (idx == REG_WIDTH)
            width_reg = data;
        else
            height_reg = data;
    endtask

    task automatic set_texture_size(input logic [8:0] w, input logic [8:0] h);
        write_size(REG_WIDTH, w);
        write_size(REG_HEIGHT, h);
    endtask

    // Compare each result with the oldest expected lookup.
    always @(posedge i_clk) begin
        t_texel_hit want;
        if (i_rst_n && o_strobe) begin
            if (pending_hits.size() == 0) begin
                $display("%0t: unexpected result rgb=%h%h%h col=%0d row=%0d",
                         $realtime, o_red, o_green, o_blue, o_col, o_row);
                error_count++;
            end else begin
                want = pending_hits.pop_front();
                if (o_red !== want.red) begin
                    $display("%0t: red expected %h actual %h", $realtime, want.red, o_red);
                    error_count++;
                end
                if (o_green !== want.green) begin
                    $display("%0t: green expected %h actual %h", $realtime, want.green,
                             o_green);
                    error_count++;
                end
                if (o_blue !== want.blue) begin
                    $display("%0t: blue expected %h actual %h", $realtime, want.blue, o_blue);
                    error_count++;
                end
                if (o_col !== want.col) begin
                    $display("%0t: col expected %0d actual %0d", $realtime, want.col, o_col);
                    error_count++;
                end
                if (o_row !== want.row) begin
                    $display("%0t: row expected %0d actual %0d", $realtime, want.row, o_row);
                    error_count++;
                end
            end
        end
    end

    // Axes, poles, the seam behind the viewer and the zero vector.
    task automatic test_directed_axes();
        lookup_sky(16'sd0, 16'sd0, 16'sd0);
        lookup_sky(16'sd32767, 16'sd0, 16'sd0);
        lookup_sky(-16'sd32768, 16'sd0, 16'sd0);
        lookup_sky(-16'sd100, 16'sd0, -16'sd1);
        lookup_sky(-16'sd100, 16'sd0, 16'sd1);
        lookup_sky(16'sd0, 16'sd0, 16'sd32767);
        lookup_sky(16'sd0, 16'sd0, -16'sd32768);
        lookup_sky(16'sd0, 16'sd32767, 16'sd0);
        lookup_sky(16'sd0, -16'sd32768, 16'sd0);
        lookup_sky(16'sd0, 16'sd1, 16'sd0);
        lookup_sky(-16'sd32768, -16'sd32768, -16'sd32768);
        lookup_sky(16'sd32767, 16'sd32767, 16'sd32767);
        lookup_sky(16'sd1, -16'sd1, 16'sd1);
        write_texel(16'hFFFF, 24'hFFFFFF);
        write_texel(16'h0000, 24'h000000);
    endtask

    // Size registers at their extremes, zero and above the maximum included.
    task automatic test_size_extremes();
        set_texture_size(9'd1, 9'd1);
        lookup_sky(16'sd5, -16'sd7, 16'sd3);
        lookup_sky(-16'sd32768, 16'sd0, 16'sd0);
        set_texture_size(9'd0, 9'd0);
        lookup_sky(16'sd9, 16'sd9, -16'sd9);
        set_texture_size(9'd511, 9'd300);
        lookup_sky(-16'sd32768, -16'sd32768, 16'sd0);
        lookup_sky(16'sd0, 16'sd32767, 16'sd0);
        lookup_sky(-16'sd200, 16'sd0, -16'sd1);
        set_texture_size(9'd256, 9'd256);
        lookup_sky(-16'sd1, -16'sd1, -16'sd1);
    endtask

    function automatic logic signed [15:0] random_component();
        case ($urandom_range(0, 3))
            0: return $urandom;
            1: return $urandom_range(0, 64) - 32;
            2: return ($urandom_range(0, 1) == 1) ? 16'sd32767 : -16'sd32768;
            default: return $urandom_range(0, 4000) - 2000;
        endcase
    endfunction

    // Random writes and lookups over several texture sizes.
    task automatic test_random_traffic();
        logic [15:0] index;
        logic signed [15:0] x;
        logic signed [15:0] z;
        for (int phase = 0; phase < 6; phase++) begin
            set_texture_size($urandom_range(0, 511), $urandom_range(0, 511));
            for (int n = 0; n < 110; n++) begin
                if (n == 55) begin
                    // Hold off the sender until everything is back.
                    i_start <= 1'b0;
                    do @(posedge i_clk); while (pending_hits.size() != 0);
                end
                if ($urandom_range(0, 3) == 0) begin
                    index = $urandom;
                    write_texel(index, $urandom);
                end else begin
                    x = random_component();
                    z = random_component();
                    if ($urandom_range(0, 9) == 0) begin
                        x = 0;
                        z = 0;
                    end
                    lookup_sky(x, random_component(), z);
                end
            end
        end
    endtask

    initial begin
        error_count = 0;
        width_reg = 9'd256;
        height_reg = 9'd128;
        i_rst_n = 1'b0;
        i_start = 1'b0;
        i_func = FUNC_WRITE;
        i_texel_index = '0;
        i_texel_rgb = '0;
        i_dir_x = '0;
        i_dir_y = '0;
        i_dir_z = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = REG_WIDTH;
        i_cfg_data = '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_axes();
        test_size_extremes();
        test_random_traffic();
        drain_pipeline();

        if (error_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
